[rtl/core/lqrbs_pkg.sv]
// ----------------------------------------------------------------------------
// lqrbs_pkg
// Shared types, register indexes, fixed-point limits and helper functions for
// the reaction-wheel balance and swing-up controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lqrbs_pkg;

   // Configuration port geometry
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_K_ANGLE_U   = 3'd0,
      CSR_K_RATE_U    = 3'd1,
      CSR_K_SPEED_U   = 3'd2,
      CSR_K_ANGLE_S   = 3'd3,
      CSR_K_RATE_S    = 3'd4,
      CSR_K_SPEED_S   = 3'd5,
      CSR_SWING_LEVEL = 3'd6,
      CSR_BAL_WINDOW  = 3'd7
   } csr_index_type;

   // Fixed-point value types (1/256 units, gains Q8.8)
   typedef logic signed [18:0] err_type;     // folded angles and error
   typedef logic signed [16:0] angle_type;   // tilt and target angle
   typedef logic signed [15:0] drive_type;   // drive target
   typedef logic signed [15:0] gain_type;    // Q8.8 gain
   typedef logic signed [19:0] rate_type;    // gyro rate
   typedef logic signed [16:0] speed_type;   // wheel speed

   typedef struct packed {
      gain_type k_angle;
      gain_type k_rate;
      gain_type k_speed;
   } gain_set_type;

   typedef struct packed {
      gain_set_type unstable;
      gain_set_type stable;
      logic [11:0]  swing_level;
      logic [14:0]  bal_window;
   } cfg_type;

   // Tracker status handed to the control law and the result register
   typedef struct packed {
      err_type   err;
      logic      balancing;
      logic      stable;
      angle_type target;
   } trk_type;

   // Register reset values
   localparam gain_type    RST_K_ANGLE_U = 16'sd3072;
   localparam gain_type    RST_K_RATE_U  = 16'sd486;
   localparam gain_type    RST_K_SPEED_U = 16'sd461;
   localparam gain_type    RST_K_ANGLE_S = 16'sd1126;
   localparam gain_type    RST_K_RATE_S  = 16'sd384;
   localparam gain_type    RST_K_SPEED_S = 16'sd364;
   localparam logic [11:0] RST_SWING_LEVEL = 12'd256;
   localparam logic [14:0] RST_BAL_WINDOW  = 15'd4608;

   // Controller limits
   localparam err_type                FOLD_LIMIT     = 19'sd23040;  // 90 degrees
   localparam logic [18:0]            DRIFT_LIMIT    = 19'd2048;    // 8 degrees
   localparam logic [31:0]            SETTLE_MS      = 32'd1000;
   localparam logic [31:0]            TRIM_MS        = 32'd2500;
   localparam logic signed [19:0]     TRIM_STEP      = 20'sd51;     // 0.2 degree
   localparam drive_type              TRIM_MIN_DRIVE = 16'sd1280;   // 5 units
   localparam drive_type              DRIVE_LIMIT    = 16'sd30720;  // 120 units
   localparam logic signed [19:0]     TARGET_LIMIT   = 20'sd46080;  // 180 degrees
   localparam angle_type              TARGET_RESET   = 17'sd15360;  // 60 degrees

   // Push an angle beyond +/-90 degrees a further 90 degrees out in its own sign
   function automatic err_type fold(input err_type x);
      err_type r;
      if (x > FOLD_LIMIT) begin
         r = x + FOLD_LIMIT;
      end else if (x < -FOLD_LIMIT) begin
         r = x - FOLD_LIMIT;
      end else begin
         r = x;
      end
      return r;
   endfunction

   // Clamp a widened target to +/-180 degrees
   function automatic angle_type sat_target(input logic signed [19:0] x);
      logic signed [19:0] r;
      if (x > TARGET_LIMIT) begin
         r = TARGET_LIMIT;
      end else if (x < -TARGET_LIMIT) begin
         r = -TARGET_LIMIT;
      end else begin
         r = x;
      end
      return r[16:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/lqrbs_csr.sv]
// ----------------------------------------------------------------------------
// lqrbs_csr
// Configuration registers: two LQR gain sets, swing-up drive level and the
// balance window. Always ready; one write per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lqrbs_csr
   import lqrbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_K_ANGLE_U:   cfg_in.unstable.k_angle = csr_data;
            CSR_K_RATE_U:    cfg_in.unstable.k_rate  = csr_data;
            CSR_K_SPEED_U:   cfg_in.unstable.k_speed = csr_data;
            CSR_K_ANGLE_S:   cfg_in.stable.k_angle   = csr_data;
            CSR_K_RATE_S:    cfg_in.stable.k_rate    = csr_data;
            CSR_K_SPEED_S:   cfg_in.stable.k_speed   = csr_data;
            CSR_SWING_LEVEL: cfg_in.swing_level      = csr_data[11:0];
            CSR_BAL_WINDOW:  cfg_in.bal_window       = csr_data[14:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unstable.k_angle <= RST_K_ANGLE_U;
         cfg_ff.unstable.k_rate  <= RST_K_RATE_U;
         cfg_ff.unstable.k_speed <= RST_K_SPEED_U;
         cfg_ff.stable.k_angle   <= RST_K_ANGLE_S;
         cfg_ff.stable.k_rate    <= RST_K_RATE_S;
         cfg_ff.stable.k_speed   <= RST_K_SPEED_S;
         cfg_ff.swing_level      <= RST_SWING_LEVEL;
         cfg_ff.bal_window       <= RST_BAL_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lqrbs_tracker.sv]
// ----------------------------------------------------------------------------
// lqrbs_tracker
// Angle error folding and the stability tracker: settle and drift timers,
// target angle adaptation and the previous drive value.
// ----------------------------------------------------------------------------
`default_nettype none

module lqrbs_tracker
   import lqrbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,      // current item moves to the result register
   input  angle_type   tilt_angle,
   input  logic [31:0] time_ms,
   input  logic        run_enable,
   input  logic [14:0] bal_window,
   input  drive_type   drive,        // drive produced for the current item
   output trk_type     trk
);

   logic              is_stable_ff,      is_stable_in;
   logic [31:0]       unstable_stamp_ff, unstable_stamp_in;
   logic [31:0]       stable_stamp_ff,   stable_stamp_in;
   angle_type         target_ff,         target_in;
   drive_type         last_drive_ff,     last_drive_in;

   err_type            tgt_ext;
   err_type            tilt_ext;
   err_type            diff;
   err_type            err;
   logic [18:0]        err_mag;
   logic               balancing;
   logic               drifted;
   logic               stable_a;
   logic [31:0]        ustamp_a;
   logic               settle;
   logic signed [19:0] tgt_w;
   logic signed [19:0] half_err_w;
   angle_type          target_a;
   logic signed [19:0] target_a_w;
   logic               big_drive;
   logic               trim;
   angle_type          target_b;

   // Folded error and balance window test
   assign tgt_ext   = 19'(target_ff);
   assign tilt_ext  = 19'(tilt_angle);
   assign diff      = fold(tgt_ext) - fold(tilt_ext);
   assign err       = fold(diff);
   assign err_mag   = err[18] ? 19'(-err) : 19'(err);
   assign balancing = err_mag < {4'd0, bal_window};

   // Instability clears the stable flag and restarts the settle timer
   assign drifted  = err_mag > DRIFT_LIMIT;
   assign stable_a = drifted ? 1'b0 : is_stable_ff;
   assign ustamp_a = drifted ? time_ms : unstable_stamp_ff;

   // Settling: add half the error to the target, moving it away from the tilt
   assign settle     = (32'(time_ms - ustamp_a) > SETTLE_MS) && !stable_a;
   assign tgt_w      = 20'(target_ff);
   assign half_err_w = 20'(err >>> 1);
   assign target_a   = settle ? sat_target(tgt_w + half_err_w) : target_ff;

   // Drift trim: step the target against a sustained drive
   assign big_drive  = (last_drive_ff > TRIM_MIN_DRIVE) || (last_drive_ff < -TRIM_MIN_DRIVE);
   assign trim       = (32'(time_ms - stable_stamp_ff) > TRIM_MS) && (stable_a || settle)
                       && big_drive;
   assign target_a_w = 20'(target_a);
   assign target_b   = !trim ? target_a :
                       last_drive_ff[15] ? sat_target(target_a_w + TRIM_STEP) :
                                           sat_target(target_a_w - TRIM_STEP);

   // Next state; adapts only inside the balance window, target resets when not running
   always_comb begin
      is_stable_in      = is_stable_ff;
      unstable_stamp_in = unstable_stamp_ff;
      stable_stamp_in   = stable_stamp_ff;
      target_in         = target_ff;
      if (balancing) begin
         is_stable_in      = stable_a | settle;
         unstable_stamp_in = ustamp_a;
         stable_stamp_in   = trim ? time_ms : stable_stamp_ff;
         target_in         = target_b;
      end
      if (!run_enable) begin
         target_in = TARGET_RESET;
      end
      last_drive_in = drive;
   end

   assign trk.err       = err;
   assign trk.balancing = balancing;
   assign trk.stable    = is_stable_in;
   assign trk.target    = target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_stable_ff      <= 1'b0;
         unstable_stamp_ff <= '0;
         stable_stamp_ff   <= '0;
         target_ff         <= TARGET_RESET;
         last_drive_ff     <= '0;
      end else if (advance) begin
         is_stable_ff      <= is_stable_in;
         unstable_stamp_ff <= unstable_stamp_in;
         stable_stamp_ff   <= stable_stamp_in;
         target_ff         <= target_in;
         last_drive_ff     <= last_drive_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lqrbs_law.sv]
// ----------------------------------------------------------------------------
// lqrbs_law
// Control law: LQR state feedback with gain set selection and saturation
// inside the balance window, bang-bang swing-up torque outside it.
// ----------------------------------------------------------------------------
`default_nettype none

module lqrbs_law
   import lqrbs_pkg::*;
(
   input  cfg_type   cfg,
   input  trk_type   trk,
   input  rate_type  gyro_rate,
   input  speed_type wheel_speed,
   input  logic      run_enable,
   output drive_type drive,
   output logic      drive_mode
);

   gain_set_type       gs;
   gain_type           k_angle;
   gain_type           k_rate;
   gain_type           k_speed;
   err_type            err;
   logic signed [34:0] p_angle;
   logic signed [35:0] p_rate;
   logic signed [32:0] p_speed;
   logic signed [37:0] acc;
   logic signed [29:0] scaled;
   drive_type          lqr_drive;
   drive_type          level;
   drive_type          swing_drive;

   // Three parallel products of the selected gain set
   assign gs      = trk.stable ? cfg.stable : cfg.unstable;
   assign k_angle = gs.k_angle;
   assign k_rate  = gs.k_rate;
   assign k_speed = gs.k_speed;
   assign err     = trk.err;
   assign p_angle = 35'(k_angle) * 35'(err);
   assign p_rate  = 36'(k_rate) * 36'(gyro_rate);
   assign p_speed = 33'(k_speed) * 33'(wheel_speed);
   assign acc     = 38'(p_angle) + 38'(p_rate) + 38'(p_speed);

   // Back to 1/256 units (floor) and clamp to +/-120
   assign scaled    = acc[37:8];
   assign lqr_drive = (scaled > DRIVE_LIMIT)  ? DRIVE_LIMIT :
                      (scaled < -DRIVE_LIMIT) ? -DRIVE_LIMIT : scaled[15:0];

   // Swing-up torque opposes the gyro direction; zero rate gives no torque
   assign level       = {4'd0, cfg.swing_level};
   assign swing_drive = (gyro_rate == '0) ? '0 :
                        gyro_rate[19]     ? level : -level;

   always_comb begin
      if (!run_enable) begin
         drive      = '0;
         drive_mode = 1'b0;
      end else if (trk.balancing) begin
         drive      = lqr_drive;
         drive_mode = 1'b1;
      end else begin
         drive      = swing_drive;
         drive_mode = 1'b0;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lqr_balance_swingup_controller.sv]
// ----------------------------------------------------------------------------
// lqr_balance_swingup_controller
// Reaction-wheel balancer with swing-up, one sample per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the req_ channel (valid/stall) and one result per sample
//   leaves on the rsp_ channel (valid/stall). A transfer happens on a rising
//   edge with valid high and stall low.
//   A sample is captured in the input register at its transfer; once the
//   result register is free it is evaluated against the tracker state and
//   lands in the result register, which raises rsp_valid.
//   Throughput is one sample per cycle while no result is stalled: the tracker
//   state (target angle, timers, previous drive) is updated in the same edge
//   that loads the result register, so the following sample sees it directly.
//   When the receiver holds rsp_stall the result register keeps its value;
//   one further sample waits in the input register and req_stall then rises
//   until the result is taken.
//   Gains, swing-up level and balance window are written on the csr_ port,
//   which is always ready; write them only while no sample is in flight.
//   Synchronous reset empties both registers, restores the default gains
//   and sets the target angle to 60 degrees with the tracker cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lqr_balance_swingup_controller
   import lqrbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [16:0]     req_tilt_angle,
   input  logic signed [19:0]     req_gyro_rate,
   input  logic signed [16:0]     req_wheel_speed,
   input  logic [31:0]            req_time_ms,
   input  logic                   req_run_enable,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [15:0]     rsp_drive_target,
   output logic                   rsp_drive_mode,
   output logic                   rsp_stable_flag,
   output logic                   rsp_balancing,
   output logic signed [16:0]     rsp_target_now,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg;
   trk_type   trk;
   drive_type drive;
   logic      drive_mode;

   // Input register
   logic        in_vld_ff, in_vld_in;
   angle_type   tilt_ff;
   rate_type    gyro_ff;
   speed_type   speed_ff;
   logic [31:0] time_ff;
   logic        run_ff;

   // Result register
   logic        out_vld_ff, out_vld_in;
   drive_type   drive_ff;
   logic        mode_ff;
   logic        stable_ff;
   logic        bal_ff;
   angle_type   target_ff;

   logic        req_take;
   logic        advance;

   // Pipeline control: the sample moves on when the result register is free
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   lqrbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lqrbs_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .tilt_angle (tilt_ff),
      .time_ms    (time_ff),
      .run_enable (run_ff),
      .bal_window (cfg.bal_window),
      .drive      (drive),
      .trk        (trk)
   );

   lqrbs_law u_law (
      .cfg         (cfg),
      .trk         (trk),
      .gyro_rate   (gyro_ff),
      .wheel_speed (speed_ff),
      .run_enable  (run_ff),
      .drive       (drive),
      .drive_mode  (drive_mode)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Sample capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         tilt_ff  <= req_tilt_angle;
         gyro_ff  <= req_gyro_rate;
         speed_ff <= req_wheel_speed;
         time_ff  <= req_time_ms;
         run_ff   <= req_run_enable;
      end
   end

   // Result capture
   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff  <= drive;
         mode_ff   <= drive_mode;
         stable_ff <= trk.stable;
         bal_ff    <= trk.balancing;
         target_ff <= trk.target;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_drive_target = drive_ff;
   assign rsp_drive_mode   = mode_ff;
   assign rsp_stable_flag  = stable_ff;
   assign rsp_balancing    = bal_ff;
   assign rsp_target_now   = target_ff;

endmodule

`default_nettype wire

[rtl/core/lqrbs_checker.sv]
// ----------------------------------------------------------------------------
// lqrbs_checker
// Port-level checks on the balance controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lqrbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_drive_target,
   input logic               rsp_drive_mode,
   input logic               rsp_balancing,
   input logic signed [16:0] rsp_target_now
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_target)
                                 && $stable(rsp_target_now))
      else $error("stalled result changed");

   // Input back-pressure only comes from a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // Velocity mode only under the balance law, and then within +/-120
   a_mode_bal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_mode |-> rsp_balancing
         && (rsp_drive_target <= 16'sd30720) && (rsp_drive_target >= -16'sd30720))
      else $error("velocity drive outside balance law or limits");

   // Adapted target stays within +/-180 degrees
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_target_now <= 17'sd46080) && (rsp_target_now >= -17'sd46080))
      else $error("target angle out of range");

endmodule

bind lqr_balance_swingup_controller lqrbs_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drive_target (rsp_drive_target),
   .rsp_drive_mode   (rsp_drive_mode),
   .rsp_balancing    (rsp_balancing),
   .rsp_target_now   (rsp_target_now)
);

`default_nettype wire
